### rtl/srl_pkg.sv
// Package for the servo linear ramp: widths, codes, sequencer states and divider interface types.
package srl_pkg;

	localparam int unsigned STEP_MS_DEF = 10;
	localparam int unsigned POS_W = 16;
	localparam int unsigned MS_W = 16;
	localparam int unsigned CNT_W = 32;
	localparam int unsigned DVS_W = POS_W + 1;
	localparam int unsigned IN_DATA_W = 32;
	localparam int unsigned OUT_DATA_W = 56;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SET = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_DIST,
		ST_SEND
	} seq_state_t;

	typedef struct packed {
		logic start;
		logic [POS_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### rtl/srl_div.sv
// Restoring divider, one quotient bit per cycle.
module srl_div
	import srl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  div_ctrl_t            ctrl,
	output div_stat_t            stat,
	output logic [POS_W-1:0]     quotient
);

	localparam int unsigned ITER_W = $clog2(POS_W);
	localparam logic [ITER_W-1:0] LAST = ITER_W'(POS_W - 1);

	logic [DVS_W-1:0] rem_q;
	logic [POS_W-1:0] dq_q;
	logic [DVS_W-1:0] dvs_q;
	logic [ITER_W-1:0] cnt_q;
	logic run_q;
	logic done_q;

	logic [DVS_W:0] trial;
	logic fits;

	assign trial = {rem_q, dq_q[POS_W-1]};
	assign fits = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= run_q && (cnt_q == LAST);
			if (ctrl.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= '0;
			dq_q <= ctrl.dividend;
			dvs_q <= ctrl.divisor;
		end else if (run_q) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			dq_q <= {dq_q[POS_W-2:0], fits};
		end
	end

	assign stat.busy = run_q;
	assign stat.done = done_q;
	assign quotient = dq_q;

endmodule

### rtl/servo_linear_ramp.sv
// Servo linear ramp top level: sequencer, position state and output register.
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  tdata: target_pos, move_ms; tuser: opcode
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata: position, step_count, moving
//
// A tick or a zero-time set loads its result into the output register in the cycle it is
// accepted; the next transfer can follow at once. A timed set runs through ST_DIV_DIST and
// ST_SEND: the step count comes from a reciprocal multiply (move_ms / STEP_MS, plus one),
// then one pass of the bit-serial divider (distance by step count) and the send state; no input meanwhile.
// Each result sits in an output register until taken; input stalls during a timed set and while
// that register is full and not being drained.
// Reset: position 0, target 0, step 1, tick count 0, output empty.
module servo_linear_ramp
	import srl_pkg::*;
#(
	parameter int unsigned STEP_MS = STEP_MS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] target_pos, [31:16] move_ms
	input  logic                  s_axis_tuser,   // [0] opcode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata    // [15:0] position, [47:16] step_count,
	                                              // [48] moving, [55:49] zero
);

	// move_ms / STEP_MS as multiply by ceil(2^RCP_SH / STEP_MS), exact for 16-bit move_ms
	localparam int unsigned RCP_SH = MS_W + $clog2(STEP_MS);
	localparam int unsigned RCP_W = MS_W + 1;
	localparam int unsigned PROD_W = MS_W + RCP_W;
	localparam longint unsigned RCP_M =
		((64'd1 << RCP_SH) + 64'(STEP_MS) - 64'd1) / 64'(STEP_MS);

	seq_state_t state_q, state_d;
	div_ctrl_t div_ctrl;
	div_stat_t div_stat;
	logic [POS_W-1:0] quot;

	logic [POS_W-1:0] cur_q, cur_d, goal_q, goal_d, step_q, tick_pos, gap;
	logic [CNT_W-1:0] total_q, total_d;
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_out_q;
	logic moving_q, m_valid_q;

	logic out_free, accept, out_load;
	logic [POS_W-1:0] in_target;
	logic [MS_W-1:0] in_ms;
	logic [PROD_W-1:0] ms_prod;
	logic [DVS_W-1:0] steps;

	assign in_target = s_axis_tdata[POS_W-1:0];
	assign in_ms = s_axis_tdata[POS_W+MS_W-1:POS_W];
	assign out_free = !m_valid_q || m_axis_tready;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign gap = (in_target > cur_q) ? in_target - cur_q : cur_q - in_target;
	assign ms_prod = PROD_W'(in_ms) * PROD_W'(RCP_M);
	assign steps = DVS_W'(ms_prod[PROD_W-1:RCP_SH]) + 1'b1;

	srl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.stat     (div_stat),
		.quotient (quot)
	);

	always_comb begin
		if (cur_q > goal_q) begin
			tick_pos = (cur_q - goal_q <= step_q) ? goal_q : cur_q - step_q;
		end else begin
			tick_pos = (goal_q - cur_q <= step_q) ? goal_q : cur_q + step_q;
		end
	end

	always_comb begin
		cur_d = cur_q;
		goal_d = goal_q;
		total_d = total_q;
		if (accept) begin
			if (s_axis_tuser == OP_SET) begin
				goal_d = in_target;
				if (in_ms == '0) begin
					cur_d = in_target;
				end
			end else if (cur_q != goal_q) begin
				cur_d = tick_pos;
				total_d = total_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		div_ctrl = '0;
		out_load = 1'b0;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = out_free;
				if (s_axis_tvalid && out_free) begin
					if (s_axis_tuser == OP_SET && in_ms != '0) begin
						div_ctrl.start = 1'b1;
						div_ctrl.dividend = gap;
						div_ctrl.divisor = steps;
						state_d = ST_DIV_DIST;
					end else begin
						out_load = 1'b1;
					end
				end
			end
			ST_DIV_DIST: begin
				if (div_stat.done) begin
					state_d = ST_SEND;
				end
			end
			ST_SEND: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q <= '0;
			goal_q <= '0;
			step_q <= POS_W'(1);
			total_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cur_q <= cur_d;
			goal_q <= goal_d;
			total_q <= total_d;
			if (state_q == ST_DIV_DIST && div_stat.done) begin
				step_q <= (quot == '0) ? POS_W'(1) : quot;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pos_q <= cur_d;
			cnt_out_q <= total_d;
			moving_q <= cur_d != goal_d;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {{(OUT_DATA_W - POS_W - CNT_W - 1){1'b0}}, moving_q, cnt_out_q, pos_q};

	a_step_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != '0)
		else $error("step size reached zero");

	a_timed_set_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tuser == OP_SET && in_ms != '0) |=> !s_axis_tready)
		else $error("input taken during timed set");

	a_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (s_axis_tuser == OP_TICK || in_ms == '0)) |=> m_axis_tvalid)
		else $error("result missing after one-cycle item");

	a_div_in_seq: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV_DIST)
		else $error("divider finished outside a divide state");

endmodule

### verif/tb_servo_linear_ramp.sv
// Self-checking testbench for servo_linear_ramp: directed table, random move sequences, scoreboard.
module tb_servo_linear_ramp;
	timeunit 1ns;
	timeprecision 1ps;

	import srl_pkg::*;

	localparam int unsigned N_DIR       = 25;
	localparam int unsigned N_ITEMS     = 1850;
	localparam int unsigned QUIET_AFTER = 1600;
	localparam int unsigned HOLD_AT     = 300;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned STALL_LIMIT = 3000;
	localparam int unsigned DRAIN_WAIT  = 40;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [CNT_W-1:0] cnt;
		logic             moving;
	} ramp_out_t;

	typedef struct packed {
		logic             op;
		logic [POS_W-1:0] tgt;
		logic [MS_W-1:0]  ms;
		logic             lit;
		ramp_out_t        res;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = OP_TICK;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// predicted block state
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] goal_q;
	logic [POS_W-1:0] step_q;
	logic [CNT_W-1:0] ticks_q;

	ramp_out_t pending_results[$];
	int unsigned n_sent, n_sets, n_ticks, n_checked, n_errors, stall_cycles;
	bit tx_bursts, rx_bursts, hold_req, hold_done;

	dir_row_t dir_rows [N_DIR] = '{
		'{OP_TICK, 16'hFFFF, 16'hFFFF, 1'b1, '{16'h0000, 32'd0, 1'b0}},
		'{OP_SET,  16'hFFFF, 16'h0000, 1'b1, '{16'hFFFF, 32'd0, 1'b0}},
		'{OP_SET,  16'h0000, 16'h0000, 1'b1, '{16'h0000, 32'd0, 1'b0}},
		'{OP_SET,  16'hFFFF, 16'hFFFF, 1'b1, '{16'h0000, 32'd0, 1'b1}},
		'{OP_TICK, 16'h0000, 16'h0000, 1'b0, '0},
		'{OP_TICK, 16'h5A5A, 16'hA5A5, 1'b0, '0},
		'{OP_SET,  16'h0000, 16'h0001, 1'b0, '0},
		'{OP_TICK, 16'hFFFF, 16'h0000, 1'b0, '0},
		'{OP_SET,  16'h0000, 16'd500,  1'b1, '{16'h0000, 32'd3, 1'b0}},
		'{OP_SET,  16'd5,    16'd1000, 1'b0, '0},
		'{OP_TICK, 16'h1234, 16'h4321, 1'b0, '0},
		'{OP_SET,  16'd100,  16'd20,   1'b0, '0},
		'{OP_TICK, 16'h0000, 16'hFFFF, 1'b0, '0},
		'{OP_TICK, 16'h0000, 16'h0000, 1'b0, '0},
		'{OP_TICK, 16'h0000, 16'h0000, 1'b0, '0},
		'{OP_TICK, 16'h0000, 16'h0000, 1'b0, '0},
		'{OP_TICK, 16'hFFFF, 16'hFFFF, 1'b0, '0},
		'{OP_SET,  16'hFFFF, 16'd10,   1'b0, '0},
		'{OP_TICK, 16'h0000, 16'h0000, 1'b0, '0},
		'{OP_TICK, 16'h0000, 16'h0000, 1'b0, '0},
		'{OP_TICK, 16'h0000, 16'h0000, 1'b0, '0},
		'{OP_SET,  16'h0000, 16'd10,   1'b0, '0},
		'{OP_TICK, 16'h0000, 16'h0000, 1'b0, '0},
		'{OP_TICK, 16'h0000, 16'h0000, 1'b0, '0},
		'{OP_TICK, 16'h0000, 16'h0000, 1'b0, '0}
	};

	servo_linear_ramp #(
		.STEP_MS(STEP_MS_DEF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	function automatic ramp_out_t ramp_advance(logic op, logic [POS_W-1:0] tgt,
			logic [MS_W-1:0] ms);
		int unsigned nsteps, gap, quo;
		ramp_out_t o;
		if (op == OP_SET) begin
			goal_q = tgt;
			if (ms != 0) begin
				nsteps = ms / STEP_MS_DEF + 1;
				gap = 32'((goal_q > pos_q) ? goal_q - pos_q : pos_q - goal_q);
				quo = gap / nsteps;
				if (quo == 0)
					quo = 1;
				step_q = quo[POS_W-1:0];
			end else begin
				pos_q = goal_q;
			end
		end else if (pos_q != goal_q) begin
			if (pos_q > goal_q) begin
				if (pos_q - goal_q <= step_q)
					pos_q = goal_q;
				else
					pos_q = pos_q - step_q;
			end else begin
				if (goal_q - pos_q <= step_q)
					pos_q = goal_q;
				else
					pos_q = pos_q + step_q;
			end
			ticks_q = ticks_q + 1;
		end
		o.pos = pos_q;
		o.cnt = ticks_q;
		o.moving = (pos_q != goal_q);
		return o;
	endfunction

	task automatic put_item(input logic op, input logic [POS_W-1:0] tgt,
			input logic [MS_W-1:0] ms, input logic lit, input ramp_out_t lit_res);
		ramp_out_t pred;
		if (tx_bursts && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {ms, tgt};
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pred = ramp_advance(op, tgt, ms);
		pending_results.push_back(lit ? lit_res : pred);
		n_sent++;
		if (op == OP_SET)
			n_sets++;
		else
			n_ticks++;
		if (!hold_done && n_sent == N_DIR + HOLD_AT) begin
			hold_req = 1'b1;
			hold_done = 1'b1;
		end
		if (n_sent == QUIET_AFTER) begin
			tx_bursts = 1'b0;
			rx_bursts = 1'b0;
		end
		@(negedge clk);
	endtask

	task automatic put_tick();
		put_item(OP_TICK, 16'($urandom), 16'($urandom), 1'b0, '0);
	endtask

	// result receiver with random stalls and one long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (rx_bursts && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// scoreboard and watchdog
	always @(posedge clk) begin
		ramp_out_t want;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result transfer, tdata=%h", m_axis_tdata);
					n_errors++;
				end else begin
					want = pending_results.pop_front();
					n_checked++;
					if (m_axis_tdata[15:0] !== want.pos) begin
						$error("position: expected %0d, got %0d", want.pos, m_axis_tdata[15:0]);
						n_errors++;
					end
					if (m_axis_tdata[47:16] !== want.cnt) begin
						$error("step_count: expected %0d, got %0d", want.cnt,
							m_axis_tdata[47:16]);
						n_errors++;
					end
					if (m_axis_tdata[48] !== want.moving) begin
						$error("moving: expected %0d, got %0d", want.moving, m_axis_tdata[48]);
						n_errors++;
					end
				end
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int unsigned budget, n, sel;
		logic [POS_W-1:0] tgt;
		logic [MS_W-1:0] ms;
		pos_q = '0;
		goal_q = '0;
		step_q = 16'd1;
		ticks_q = '0;
		tx_bursts = 1'b1;
		rx_bursts = 1'b1;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIR; i++)
			put_item(dir_rows[i].op, dir_rows[i].tgt, dir_rows[i].ms, dir_rows[i].lit,
				dir_rows[i].res);

		while (n_sent < N_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: unrelated items in any order
				repeat ($urandom_range(1, 4))
					put_item(1'($urandom), 16'($urandom), 16'($urandom), 1'b0, '0);
			end else begin
				sel = $urandom_range(0, 9);
				tgt = (sel == 0) ? pos_q : 16'($urandom);
				sel = $urandom_range(0, 9);
				if (sel < 2)
					ms = '0;
				else if (sel < 7)
					ms = 16'($urandom_range(1, 300));
				else if (sel < 9)
					ms = 16'($urandom_range(301, 3000));
				else
					ms = 16'($urandom);
				put_item(OP_SET, tgt, ms, 1'b0, '0);
				budget = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 40;
				n = 0;
				while (n < budget && pos_q != goal_q) begin
					put_tick();
					n++;
				end
				repeat ($urandom_range(0, 2))
					put_tick();
			end
		end
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Run covered %0d set-target and %0d tick transfers, %0d results checked,",
			n_sets, n_ticks, n_checked);
		$display("with random stalls on both sides and one long output hold-off.");
		if (n_errors == 0 && pending_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### servo_linear_ramp.f
rtl/srl_pkg.sv
rtl/srl_div.sv
rtl/servo_linear_ramp.sv
verif/tb_servo_linear_ramp.sv
